// ----- rtl/bmf_pkg.sv -----
// ============================================================================
// bmf_pkg
// Shared types, codes and constants of the box mean filter.
// ============================================================================
`default_nettype none

package bmf_pkg;

  // Default largest image the tables hold
  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  // Fixed field widths
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 32;
  localparam int POS_W  = 7;
  localparam int RAD_W  = 6;
  localparam int DIM_W  = 8;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [RAD_W-1:0] RADIUS_RST = 6'd1;
  localparam logic [DIM_W-1:0] DIM_RST    = 8'd128;

  // Opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PIX_W-1:0] pixel_in;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_pixel;
    logic             valid_res;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LDWR,
    ST_LOOK,
    ST_LAST,
    ST_DIVGO,
    ST_DIV
  } state_t;

  // Window corners of the integral lookup
  typedef enum logic [1:0] {
    CRN_A,   // bottom right
    CRN_B,   // above the window, right
    CRN_C,   // left of the window, bottom
    CRN_D    // above and left
  } corner_t;

  // Table strobes
  typedef struct packed {
    logic sum_rd;
    logic alpha_rd;
    logic wr;
  } tab_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/bmf_table.sv -----
// ============================================================================
// bmf_table
// Integral sum memory (red, green, blue per word) and alpha memory,
// one write port, registered reads.
// ============================================================================
`default_nettype none

module bmf_table import bmf_pkg::*; #(
  parameter int DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF),
  parameter int SUM_W  = CHAN_W + $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF)
) (
  input  wire  logic                 clk,
  input  wire  tab_ctl_t             ctl,
  input  wire  logic [ADDR_W-1:0]    sum_rd_addr,
  input  wire  logic [ADDR_W-1:0]    alpha_rd_addr,
  input  wire  logic [ADDR_W-1:0]    wr_addr,
  input  wire  logic [3*SUM_W-1:0]   wr_sum,
  input  wire  logic [CHAN_W-1:0]    wr_alpha,
  output logic       [3*SUM_W-1:0]   rd_sum,
  output logic       [CHAN_W-1:0]    rd_alpha
);

  logic [3*SUM_W-1:0] sum_mem   [DEPTH];
  logic [CHAN_W-1:0]  alpha_mem [DEPTH];

  // Write one pixel entry
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      sum_mem[wr_addr]   <= wr_sum;
      alpha_mem[wr_addr] <= wr_alpha;
    end
  end

  // Read, hold data between reads
  always_ff @(posedge clk) begin
    if (ctl.sum_rd) begin
      rd_sum <= sum_mem[sum_rd_addr];
    end
    if (ctl.alpha_rd) begin
      rd_alpha <= alpha_mem[alpha_rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bmf_div.sv -----
// ============================================================================
// bmf_div
// Three-lane restoring divider: window sums over window area, one quotient
// bit per lane each cycle.
// ============================================================================
`default_nettype none

module bmf_div import bmf_pkg::*; #(
  parameter int SUM_W  = CHAN_W + $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF),
  parameter int AREA_W = $clog2(MAX_WIDTH_DEF + 1) + $clog2(MAX_HEIGHT_DEF + 1)
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  start,
  input  wire  logic [3*SUM_W-1:0]    dividend,
  input  wire  logic [AREA_W-1:0]     divisor,
  output logic                        done,
  output logic       [3*CHAN_W-1:0]   quot
);

  localparam int DW     = AREA_W + CHAN_W;
  localparam int STEP_W = $clog2(CHAN_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CHAN_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DW-1:0]     dsr_r;
  logic [DW-1:0]     rem_r [3];
  logic [CHAN_W-1:0] q_r   [3];

  // Sequence the quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == STEP_LAST);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Compare and subtract the shifted divisor in each lane
  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= DW'({divisor, {CHAN_W{1'b0}}} >> 1);
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= DW'(dividend[i*SUM_W +: SUM_W]);
        q_r[i]   <= '0;
      end
    end else if (busy_r) begin
      dsr_r <= dsr_r >> 1;
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= dsr_r) begin
          rem_r[i] <= rem_r[i] - dsr_r;
          q_r[i]   <= {q_r[i][CHAN_W-2:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][CHAN_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  assign quot = {q_r[2], q_r[1], q_r[0]};

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && (step_r == STEP_LAST)) |=> done_r)
    else $error("divider missed its done pulse");
`endif

endmodule

`default_nettype wire

// ----- rtl/box_mean_filter_integral_unit.sv -----
// ============================================================================
// box_mean_filter_integral_unit
// Box mean blur over a summed-area table held in on-chip memory.
// ============================================================================
// Usage:
//   Input transactions are taken when start is high and busy is low.
//   Opcode load appends the next pixel in raster order (a row-above lookup,
//   skipped on row 0, then a write back). Opcode restart resets the load
//   position in the accept cycle. Opcode read returns one result: when the
//   image is complete and the position lies inside it, the four window
//   corners are read from the sum memory one per cycle, then the divider
//   forms the three means; out_valid rises at the same edge where busy
//   drops. A read that finds the image incomplete or the position outside
//   it strobes a zero result on the cycle after accept and leaves busy low.
//   Throughput is set by the single memory read port and the bit-per-cycle
//   divider; a new transaction is taken only once busy is low.
//   Configuration writes (radius, width, height) are taken while the unit
//   is idle and start is low; a width or height write restarts loading.
//   Results appear on out_item for exactly one cycle with out_valid; the
//   receiver cannot stall the unit.
//   Reset (synchronous, active low) restores radius 1, width and height
//   128 and the load position; memory contents need no clearing.
// ============================================================================
`default_nettype none

module box_mean_filter_integral_unit import bmf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  start,
  output logic                        busy,
  input  wire  in_item_t              in_item,
  output logic                        out_valid,
  output out_item_t                   out_item,
  input  wire  logic                  cfg_valid,
  output logic                        cfg_ready,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [DIM_W-1:0]      cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W  = CHAN_W + ADDR_W;
  localparam int RS_W   = CHAN_W + COL_W;
  localparam int AREA_W = HGT_W + WID_W;
  localparam int EXT_W  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 256);

  function automatic logic [ADDR_W-1:0] tab_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    tab_addr = ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

  // Control state
  state_t            state_r, state_nxt;
  logic [RAD_W-1:0]  radius_r;
  logic [DIM_W-1:0]  width_r, height_r;
  logic [HGT_W-1:0]  load_row_r;
  logic [COL_W-1:0]  load_col_r;
  logic [RS_W-1:0]   rs_r [3];
  logic              rd_pend_r;
  logic              out_valid_r;

  // Payload registers
  corner_t           crn_r, rd_crn_r;
  logic [CHAN_W-1:0] px_alpha_r, alpha_r;
  logic [ROW_W-1:0]  r0_r, r1_r, prow_r;
  logic [COL_W-1:0]  c0_r, c1_r, pcol_r;
  logic              r0z_r, c0z_r;
  logic [AREA_W-1:0] area_r;
  logic [SUM_W-1:0]  acc_r [3];
  out_item_t         out_item_r;

  // Combinational
  logic [HGT_W-1:0]   h_eff;
  logic [WID_W-1:0]   w_eff;
  logic               accept, load_ok, full, rq_ok, last_col;
  logic [EXT_W-1:0]   r_e, c_e, rad_e, h_e, w_e, r0_e, r1_e, c0_e, c1_e;
  logic [HGT_W-1:0]   hspan;
  logic [WID_W-1:0]   wspan;
  tab_ctl_t           tab_ctl;
  logic [ADDR_W-1:0]  sum_rd_addr, wr_addr, alpha_rd_addr;
  logic [3*SUM_W-1:0] rd_sum, wr_sum;
  logic [CHAN_W-1:0]  rd_alpha;
  logic [SUM_W-1:0]   crn_val [3];
  logic               crn_zero;
  logic               div_start, div_done;
  logic [3*SUM_W-1:0] div_dividend;
  logic [3*CHAN_W-1:0] div_quot;

  // Clamp the image size registers to the table; a zero size counts as one
  always_comb begin
    if (height_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HGT_W'(height_r);
    end
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_r);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign full      = (load_row_r >= h_eff);
  assign load_ok   = (load_row_r < h_eff) && (WID_W'(load_col_r) < w_eff);
  assign last_col  = (WID_W'(load_col_r) + WID_W'(1)) >= w_eff;

  // Window bounds, clipped to the image
  always_comb begin
    r_e   = EXT_W'(in_item.row);
    c_e   = EXT_W'(in_item.col);
    rad_e = EXT_W'(radius_r);
    h_e   = EXT_W'(h_eff);
    w_e   = EXT_W'(w_eff);
    rq_ok = full && (r_e < h_e) && (c_e < w_e);
    r0_e  = (r_e > rad_e) ? (r_e - rad_e) : '0;
    c0_e  = (c_e > rad_e) ? (c_e - rad_e) : '0;
    r1_e  = ((r_e + rad_e) < h_e) ? (r_e + rad_e) : (h_e - EXT_W'(1));
    c1_e  = ((c_e + rad_e) < w_e) ? (c_e + rad_e) : (w_e - EXT_W'(1));
  end

  assign hspan = HGT_W'(r1_r) - HGT_W'(r0_r) + HGT_W'(1);
  assign wspan = WID_W'(c1_r) - WID_W'(c0_r) + WID_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.opcode == OP_LOAD) && load_ok) begin
          state_nxt = ST_LDWR;
        end else if (accept && (in_item.opcode == OP_READ) && rq_ok) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LDWR:  state_nxt = ST_IDLE;
      ST_LOOK: begin
        if (crn_r == CRN_D) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:  state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memory strobes, addresses and divider start
  always_comb begin
    tab_ctl       = '0;
    div_start     = 1'b0;
    sum_rd_addr   = tab_addr(ROW_W'(load_row_r - HGT_W'(1)), load_col_r);
    alpha_rd_addr = tab_addr(prow_r, pcol_r);
    wr_addr       = tab_addr(ROW_W'(load_row_r), load_col_r);
    unique case (state_r)
      ST_IDLE: begin
        tab_ctl.sum_rd = accept && (in_item.opcode == OP_LOAD) && load_ok &&
                         (load_row_r != '0);
      end
      ST_LDWR: begin
        tab_ctl.wr = 1'b1;
      end
      ST_LOOK: begin
        tab_ctl.sum_rd   = 1'b1;
        tab_ctl.alpha_rd = (crn_r == CRN_A);
        unique case (crn_r)
          CRN_A: sum_rd_addr = tab_addr(r1_r, c1_r);
          CRN_B: sum_rd_addr = tab_addr(r0_r - ROW_W'(1), c1_r);
          CRN_C: sum_rd_addr = tab_addr(r1_r, c0_r - COL_W'(1));
          CRN_D: sum_rd_addr = tab_addr(r0_r - ROW_W'(1), c0_r - COL_W'(1));
          default: sum_rd_addr = tab_addr(r1_r, c1_r);
        endcase
      end
      ST_DIVGO: begin
        div_start = 1'b1;
      end
      default: begin
        tab_ctl = '0;
      end
    endcase
  end

  // Write data: column above plus running row sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wr_sum[i*SUM_W +: SUM_W] = ((load_row_r == '0) ? '0 : rd_sum[i*SUM_W +: SUM_W]) +
                                 SUM_W'(rs_r[i]);
    end
  end

  // Corner value, zero where the corner falls outside the image
  always_comb begin
    case (rd_crn_r)
      CRN_B:   crn_zero = r0z_r;
      CRN_C:   crn_zero = c0z_r;
      CRN_D:   crn_zero = r0z_r || c0z_r;
      default: crn_zero = 1'b0;
    endcase
    for (int i = 0; i < 3; i++) begin
      crn_val[i] = crn_zero ? '0 : rd_sum[i*SUM_W +: SUM_W];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radius_r    <= RADIUS_RST;
      width_r     <= DIM_RST;
      height_r    <= DIM_RST;
      load_row_r  <= '0;
      load_col_r  <= '0;
      rs_r[0]     <= '0;
      rs_r[1]     <= '0;
      rs_r[2]     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= (state_r == ST_LOOK);
      out_valid_r <= (accept && (in_item.opcode == OP_READ) && !rq_ok) ||
                     ((state_r == ST_DIV) && div_done);

      // Register writes; size changes restart loading
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
          CFG_WIDTH:  width_r  <= cfg_data;
          CFG_HEIGHT: height_r <= cfg_data;
          default:    radius_r <= radius_r;
        endcase
        if ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT)) begin
          load_row_r <= '0;
          load_col_r <= '0;
          for (int i = 0; i < 3; i++) begin
            rs_r[i] <= '0;
          end
        end
      end else if (accept && (in_item.opcode == OP_RESTART)) begin
        load_row_r <= '0;
        load_col_r <= '0;
        for (int i = 0; i < 3; i++) begin
          rs_r[i] <= '0;
        end
      end else if (accept && (in_item.opcode == OP_LOAD) && load_ok) begin
        for (int i = 0; i < 3; i++) begin
          rs_r[i] <= rs_r[i] + RS_W'(in_item.pixel_in[16-8*i +: CHAN_W]);
        end
      end else if (state_r == ST_LDWR) begin
        // Advance the load position
        if (last_col) begin
          load_col_r <= '0;
          load_row_r <= load_row_r + HGT_W'(1);
          for (int i = 0; i < 3; i++) begin
            rs_r[i] <= '0;
          end
        end else begin
          load_col_r <= load_col_r + COL_W'(1);
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept && (in_item.opcode == OP_LOAD)) begin
      px_alpha_r <= in_item.pixel_in[PIX_W-1 -: CHAN_W];
    end

    // Capture the clipped window of a read
    if (accept && (in_item.opcode == OP_READ)) begin
      r0_r   <= ROW_W'(r0_e);
      r1_r   <= ROW_W'(r1_e);
      c0_r   <= COL_W'(c0_e);
      c1_r   <= COL_W'(c1_e);
      r0z_r  <= (r0_e == '0);
      c0z_r  <= (c0_e == '0);
      prow_r <= ROW_W'(in_item.row);
      pcol_r <= COL_W'(in_item.col);
      crn_r  <= CRN_A;
    end else if (state_r == ST_LOOK) begin
      crn_r  <= corner_t'(crn_r + 2'd1);
      area_r <= AREA_W'(hspan) * AREA_W'(wspan);
    end
    rd_crn_r <= crn_r;

    // Combine the corners: A - B - C + D
    if (rd_pend_r) begin
      for (int i = 0; i < 3; i++) begin
        case (rd_crn_r)
          CRN_A:   acc_r[i] <= crn_val[i];
          CRN_D:   acc_r[i] <= acc_r[i] + crn_val[i];
          default: acc_r[i] <= acc_r[i] - crn_val[i];
        endcase
      end
      if (rd_crn_r == CRN_A) begin
        alpha_r <= rd_alpha;
      end
    end

    // Form the result
    if (accept && (in_item.opcode == OP_READ) && !rq_ok) begin
      out_item_r <= '0;
    end else if ((state_r == ST_DIV) && div_done) begin
      out_item_r.filtered_pixel <= {alpha_r, div_quot[0 +: CHAN_W],
                                    div_quot[CHAN_W +: CHAN_W],
                                    div_quot[2*CHAN_W +: CHAN_W]};
      out_item_r.valid_res      <= 1'b1;
    end
  end

  assign div_dividend = {acc_r[2], acc_r[1], acc_r[0]};
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

  bmf_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .SUM_W  (SUM_W)
  ) u_table (
    .clk           (clk),
    .ctl           (tab_ctl),
    .sum_rd_addr   (sum_rd_addr),
    .alpha_rd_addr (alpha_rd_addr),
    .wr_addr       (wr_addr),
    .wr_sum        (wr_sum),
    .wr_alpha      (px_alpha_r),
    .rd_sum        (rd_sum),
    .rd_alpha      (rd_alpha)
  );

  bmf_div #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (area_r),
    .done     (div_done),
    .quot     (div_quot)
  );

`ifndef SYNTHESIS
  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && div_done) |=> out_valid)
    else $error("division finished without a result strobe");

  a_look_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) |-> (load_row_r >= h_eff))
    else $error("window lookup on an incomplete image");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.valid_res) |-> (out_item.filtered_pixel == '0))
    else $error("invalid result carries pixel data");

  a_read_look: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.opcode == OP_READ) && rq_ok) |=> (state_r == ST_LOOK))
    else $error("valid read did not start the lookup");
`endif

endmodule

`default_nettype wire
